// ===== sv/assert_macros.svh =====
// assertion helpers, empty for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_CLK_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_CLK_RST(label, clk, prop, msg)
`endif
`endif

// ===== sv/cau_pkg.sv =====
package cau_pkg;
    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_SUB = 2'd1;
    localparam logic [1:0] ACT_MUL = 2'd2;
    localparam logic [1:0] ACT_DIV = 2'd3;

    localparam int PROD_W = 33;
    localparam int DEN_W  = 32;

    // classified item handed from front to back
    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] a_re;
        logic signed [15:0] a_im;
        logic signed [15:0] b_re;
        logic signed [15:0] b_im;
    } t_item;
endpackage

// ===== sv/complex_arithmetic_unit.sv =====
// complex add, subtract, multiply and divide on signed q8.8 operands. one
// transaction enters per cycle and one result leaves per cycle while the
// output is not stalled; each result passes the input queue, the product
// registers, the sum and sign registers, the divider load registers, then a
// pipelined divider of one quotient bit per stage over 33 + FRAC_BITS bits
// or the delay line beside it; sign and saturation follow the last stage
// without a register. all actions pass through the same pipeline so results
// come back in order. a stalled result freezes the back pipeline, and once
// the two-entry input queue fills o_stall rises on the input side.
`include "assert_macros.svh"
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_action,
    input  logic signed [15:0] i_a_re,
    input  logic signed [15:0] i_a_im,
    input  logic signed [15:0] i_b_re,
    input  logic signed [15:0] i_b_im,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_r_re,
    output logic signed [15:0] o_r_im,
    output logic               o_overflow,
    output logic               o_div_by_zero
);
    import cau_pkg::*;

    t_item in_item, q_item;
    logic  q_valid, q_stall;

    assign in_item = '{action: i_action, a_re: i_a_re, a_im: i_a_im,
                       b_re: i_b_re, b_im: i_b_im};

    cau_front #(.DEPTH_LOG2(1)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(in_item),
        .o_valid(q_valid), .i_stall(q_stall), .o_item(q_item)
    );

    cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_stall(q_stall), .i_item(q_item),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_r_re(o_r_re), .o_r_im(o_r_im),
        .o_overflow(o_overflow), .o_div_by_zero(o_div_by_zero)
    );

    `ASSERT_CLK(a_in_hold, i_clk, i_rst_n, (i_valid && o_stall) |=> i_valid, "input valid dropped while stalled")
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_r_re) && $stable(o_r_im)), "result changed while stalled")
    `ASSERT_CLK(a_flags, i_clk, i_rst_n, (o_valid && o_div_by_zero) |-> (o_r_re == 16'sd0 && o_r_im == 16'sd0), "nonzero result with zero divisor")
endmodule

// ===== sv/cau_front.sv =====
`include "assert_macros.svh"
module cau_front #(
    parameter int DEPTH_LOG2 = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  cau_pkg::t_item  i_item,
    output logic            o_valid,
    input  logic            i_stall,
    output cau_pkg::t_item  o_item
);
    import cau_pkg::*;

    localparam int DEPTH = 1 << DEPTH_LOG2;

    t_item                 r_mem [DEPTH];
    logic [DEPTH_LOG2-1:0] r_wr, r_rd;
    logic [DEPTH_LOG2:0]   r_cnt, n_cnt;
    logic                  push, pop;

    assign o_stall = (r_cnt == (DEPTH_LOG2+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) n_cnt = r_cnt + 1'b1;
        else if (pop && !push) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= n_cnt;
        end
    end

    `ASSERT_CLK(a_cnt_range, i_clk, i_rst_n, r_cnt <= (DEPTH_LOG2+1)'(DEPTH), "queue count past depth")
    `ASSERT_CLK(a_cnt_track, i_clk, i_rst_n, (push && !pop) |=> (r_cnt == $past(r_cnt) + 1'b1), "queue count lost a push")
    `ASSERT_CLK_RST(a_rst_empty, i_clk, !i_rst_n |=> !o_valid, "queue not empty after reset")
endmodule

// ===== sv/cau_div.sv =====
// restoring divider, one quotient bit per stage, fully pipelined
// unsigned numerator num_w bits by unsigned DEN_W bits
module cau_div #(
    parameter int NUM_W = 41,
    parameter int TAG_W = 8
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [NUM_W-1:0]          i_num,
    input  logic [cau_pkg::DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0]          i_tag,
    output logic [NUM_W-1:0]          o_quo,
    output logic [TAG_W-1:0]          o_tag
);
    import cau_pkg::*;

    logic [DEN_W:0]     r_rem [NUM_W+1];
    logic [NUM_W-1:0]   r_num [NUM_W+1];
    logic [DEN_W-1:0]   r_den [NUM_W+1];
    logic [TAG_W-1:0]   r_tag [NUM_W+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_num[0] <= i_num;
            r_den[0] <= i_den;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [DEN_W+1:0] trial;
        logic [DEN_W:0]   shifted;
        assign shifted = {r_rem[s][DEN_W-1:0], r_num[s][NUM_W-1]};
        assign trial   = {1'b0, shifted} - {2'b00, r_den[s]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= trial[DEN_W+1] ? shifted : trial[DEN_W:0];
                r_num[s+1] <= {r_num[s][NUM_W-2:0], ~trial[DEN_W+1]};
                r_den[s+1] <= r_den[s];
                r_tag[s+1] <= r_tag[s];
            end
        end
    end

    assign o_quo = r_num[NUM_W];
    assign o_tag = r_tag[NUM_W];
endmodule

// ===== sv/cau_back.sv =====
`include "assert_macros.svh"
module cau_back #(
    parameter int FRAC_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  cau_pkg::t_item      i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [15:0]  o_r_re,
    output logic signed [15:0]  o_r_im,
    output logic                o_overflow,
    output logic                o_div_by_zero
);
    import cau_pkg::*;

    localparam int NUM_W = PROD_W + FRAC_BITS;
    localparam int TAG_W = 5;

    // whole pipeline holds while a finished result waits at the output
    logic adv, take, fin_v;
    assign adv     = !(fin_v && i_stall);
    assign take    = i_valid && adv;
    assign o_stall = !adv;

    // stage 1: products, and add/subtract sums
    logic               r1_v;
    logic [1:0]         r1_act;
    logic signed [31:0] r1_p_rr, r1_p_ii, r1_p_ri, r1_p_ir;
    logic signed [16:0] r1_s_re, r1_s_im;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r1_v <= 1'b0;
        else if (adv)  r1_v <= take;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_act  <= i_item.action;
            r1_p_rr <= i_item.a_re * i_item.b_re;
            r1_p_ii <= i_item.a_im * i_item.b_im;
            r1_p_ri <= i_item.a_re * i_item.b_im;
            r1_p_ir <= i_item.a_im * i_item.b_re;
            r1_s_re <= (i_item.action == ACT_SUB)
                     ? 17'(i_item.a_re) - 17'(i_item.b_re) : 17'(i_item.a_re) + 17'(i_item.b_re);
            r1_s_im <= (i_item.action == ACT_SUB)
                     ? 17'(i_item.a_im) - 17'(i_item.b_im) : 17'(i_item.a_im) + 17'(i_item.b_im);
        end
    end

    // stage 2: sums, signs, magnitudes, divisor check, linear results
    logic signed [PROD_W-1:0] d_nr, d_ni, m_re, m_im;
    assign d_nr  = PROD_W'(r1_p_rr) + PROD_W'(r1_p_ii);
    assign d_ni  = PROD_W'(r1_p_ir) - PROD_W'(r1_p_ri);
    assign m_re  = PROD_W'(r1_p_rr) - PROD_W'(r1_p_ii);
    assign m_im  = PROD_W'(r1_p_ri) + PROD_W'(r1_p_ir);

    // divisor needs b_re^2 + b_im^2: carried from stage 0
    logic [DEN_W-1:0] r1_den;
    logic [DEN_W-1:0] r0_den_sum;
    assign r0_den_sum = DEN_W'(i_item.b_re * i_item.b_re) + DEN_W'(i_item.b_im * i_item.b_im);
    always_ff @(posedge i_clk) begin
        if (adv) r1_den <= r0_den_sum;
    end

    logic               r2_v;
    logic [1:0]         r2_act;
    logic               r2_neg_re, r2_neg_im, r2_dz;
    logic [PROD_W-1:0]  r2_mag_re, r2_mag_im;
    logic [DEN_W-1:0]   r2_den;
    logic signed [PROD_W-1:0] r2_lin_re, r2_lin_im;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r2_v <= 1'b0;
        else if (adv)  r2_v <= r1_v;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_act    <= r1_act;
            r2_neg_re <= d_nr[PROD_W-1];
            r2_neg_im <= d_ni[PROD_W-1];
            r2_mag_re <= d_nr[PROD_W-1] ? PROD_W'(-d_nr) : PROD_W'(d_nr);
            r2_mag_im <= d_ni[PROD_W-1] ? PROD_W'(-d_ni) : PROD_W'(d_ni);
            r2_den    <= (r1_den == '0) ? DEN_W'(1) : r1_den;
            r2_dz     <= (r1_den == '0);
            if (r1_act == ACT_MUL) begin
                r2_lin_re <= m_re >>> FRAC_BITS;
                r2_lin_im <= m_im >>> FRAC_BITS;
            end else begin
                r2_lin_re <= PROD_W'(r1_s_re);
                r2_lin_im <= PROD_W'(r1_s_im);
            end
        end
    end

    // dividers, item data rides as tag through a side delay line
    logic [NUM_W-1:0] q_re, q_im;
    logic [TAG_W-1:0] tag_in, tag_re, tag_im;
    assign tag_in = {r2_v, r2_act, r2_neg_re, r2_neg_im};

    cau_div #(.NUM_W(NUM_W), .TAG_W(TAG_W)) u_div_re (
        .i_clk(i_clk), .i_en(adv), .i_num(NUM_W'(r2_mag_re) << FRAC_BITS), .i_den(r2_den),
        .i_tag(tag_in), .o_quo(q_re), .o_tag(tag_re)
    );
    cau_div #(.NUM_W(NUM_W), .TAG_W(TAG_W)) u_div_im (
        .i_clk(i_clk), .i_en(adv), .i_num(NUM_W'(r2_mag_im) << FRAC_BITS), .i_den(r2_den),
        .i_tag(tag_in), .o_quo(q_im), .o_tag(tag_im)
    );

    logic signed [PROD_W-1:0] r_lin_re [NUM_W+1];
    logic signed [PROD_W-1:0] r_lin_im [NUM_W+1];
    logic                     r_dz     [NUM_W+1];
    logic                     r_pv     [NUM_W+1];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_lin_re[0] <= r2_lin_re;
            r_lin_im[0] <= r2_lin_im;
            r_dz[0]     <= r2_dz;
            for (int k = 0; k < NUM_W; k++) begin
                r_lin_re[k+1] <= r_lin_re[k];
                r_lin_im[k+1] <= r_lin_im[k];
                r_dz[k+1]     <= r_dz[k];
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NUM_W; k++) r_pv[k] <= 1'b0;
        end else if (adv) begin
            r_pv[0] <= r2_v;
            for (int k = 0; k < NUM_W; k++) r_pv[k+1] <= r_pv[k];
        end
    end
    assign fin_v = r_pv[NUM_W];

    // final: sign, select, saturate
    logic [1:0]               f_act;
    logic                     f_div, f_dz, f_ovf;
    logic signed [NUM_W+1:0]  f_val_re, f_val_im;
    logic signed [15:0]       f_re, f_im;
    assign f_act = tag_re[3:2];
    assign f_div = (f_act == ACT_DIV);
    assign f_dz  = f_div && r_dz[NUM_W];

    function automatic logic signed [15:0] sat(input logic signed [NUM_W+1:0] v);
        if (v > (NUM_W+2)'(32767))       return 16'sh7fff;
        else if (v < -(NUM_W+2)'(32768)) return -16'sh8000;
        else                              return v[15:0];
    endfunction

    always_comb begin
        if (f_div) begin
            f_val_re = tag_re[1] ? -(NUM_W+2)'(q_re) : (NUM_W+2)'(q_re);
            f_val_im = tag_im[0] ? -(NUM_W+2)'(q_im) : (NUM_W+2)'(q_im);
        end else begin
            f_val_re = (NUM_W+2)'(r_lin_re[NUM_W]);
            f_val_im = (NUM_W+2)'(r_lin_im[NUM_W]);
        end
        f_re  = sat(f_val_re);
        f_im  = sat(f_val_im);
        f_ovf = !f_dz && ((f_val_re != (NUM_W+2)'(f_re)) || (f_val_im != (NUM_W+2)'(f_im)));
        if (f_dz) begin
            f_re = '0;
            f_im = '0;
        end
    end

    assign o_valid       = fin_v;
    assign o_r_re        = f_re;
    assign o_r_im        = f_im;
    assign o_overflow    = f_ovf;
    assign o_div_by_zero = f_dz;

    `ASSERT_CLK(a_stall_hold, i_clk, i_rst_n, (fin_v && i_stall) |=> fin_v, "result dropped while stalled")
    `ASSERT_CLK(a_tag_match, i_clk, i_rst_n, fin_v |-> tag_re[4], "divider tag out of step")
    `ASSERT_CLK(a_dz_clean, i_clk, i_rst_n, (fin_v && f_dz) |-> !f_ovf, "overflow with zero divisor")
endmodule
